// ----- hdl/coptr_pkg.sv -----
// shared constants, types and codes for the center-out pulse trail renderer
`timescale 1ns / 1ps
`default_nettype none
package coptr_pkg;

    localparam int MAX_PULSES = 8;
    localparam int PIDX_W     = $clog2(MAX_PULSES);
    localparam int CNT_W      = $clog2(MAX_PULSES + 1);
    localparam int MAX_LEDS   = 1024;
    localparam int LEN_W      = 11;
    localparam int PIX_W      = 10;
    localparam int SPEED_W    = 20;
    localparam int SPAN_W     = 20;
    localparam int INTV_W     = 16;
    localparam int COL_W      = 8;
    localparam int OFF_W      = 32;
    localparam int ELAPSED_W  = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int FIX_ONE    = 1000;
    localparam int HALF_FIX   = FIX_ONE / 2;
    localparam int CTR_W      = 19;
    localparam int LIM_W      = 21;
    localparam int PK_W       = 20;
    localparam int STEP_W     = 27;
    localparam int PROD_W     = SPEED_W + ELAPSED_W;
    localparam int DEN_W      = 20;
    localparam int ITER_W     = 6;
    localparam int BRI_W      = 10;
    localparam int BX_W       = 30;
    localparam int CX_W       = COL_W + BRI_W;
    localparam int HEAD_W     = OFF_W + 2;
    localparam int LIVE_W     = 4;
    localparam int SPQ_W      = 11;
    localparam int SPR_W      = 10;
    // reciprocal of 1000, exact for operands below 2^26
    localparam int RCP_IN_W   = 26;
    localparam int RCP_M_W    = 27;
    localparam int RCP_M      = 68719477;
    localparam int RCP_SH     = 36;
    localparam int RCP_P_W    = RCP_IN_W + RCP_M_W;
    localparam int RCP_Q_W    = RCP_P_W - RCP_SH;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED    = 3'd0,
        CFG_STRIP_LEN  = 3'd1,
        CFG_SPEED      = 3'd2,
        CFG_TRAIL_SPAN = 3'd3,
        CFG_INTERVAL   = 3'd4,
        CFG_HEAD_RED   = 3'd5,
        CFG_HEAD_GREEN = 3'd6,
        CFG_HEAD_BLUE  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PAINT_NONE  = 2'd0,
        PAINT_HEAD  = 2'd1,
        PAINT_TRAIL = 2'd2
    } paint_t;

    typedef struct packed {
        logic accept;
        logic step_start;
        logic spawn;
        logic walk_tick;
        logic walk_end;
        logic walk_query;
        logic bright_start;
        logic bright_store;
        logic chan_start;
        logic chan_store;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic enabled;
        logic in_range;
        logic walk_done;
        logic is_trail;
        logic div_busy;
        logic ch_last;
    } sts_t;

endpackage
`default_nettype wire

// ----- hdl/coptr_if.sv -----
// word channel interfaces for input items and results
`timescale 1ns / 1ps
`default_nettype none
interface coptr_in_if;
    import coptr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [PIX_W-1:0]     pixel_index;
    modport source (output valid, command, elapsed_ms, pixel_index, input ready);
    modport sink (input valid, command, elapsed_ms, pixel_index, output ready);
endinterface

interface coptr_out_if;
    import coptr_pkg::*;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  out_red;
    logic [COL_W-1:0]  out_green;
    logic [COL_W-1:0]  out_blue;
    logic [LIVE_W-1:0] live_pulses;
    logic              spawn_dropped;
    modport source (output valid, out_red, out_green, out_blue, live_pulses,
                    spawn_dropped, input ready);
    modport sink (input valid, out_red, out_green, out_blue, live_pulses,
                  spawn_dropped, output ready);
endinterface
`default_nettype wire

// ----- hdl/center_out_pulse_trail_renderer_core.sv -----
// top level of the center-out pulse trail renderer
//
//  channel   dir  handshake      word
//  in_ch     in   valid/ready    command, elapsed_ms, pixel_index
//  out_ch    out  valid/ready    out_red, out_green, out_blue, live_pulses,
//                                spawn_dropped
//  cfg       in   cfg_we         cfg_index, cfg_data
//
//  one item at a time; a tick walks every stored pulse, the step coming
//  from two short reciprocal multiplies by 1/1000
//  a query walks every live pulse, and when a trail paints the pixel it
//  goes on to a brightness divide, then three channel scales
//  disabled block or pixel beyond the strip: straight to the output word
//  a finished word waits in the output register while the next item is taken
//  reset clears pulses and timer and sets the configuration to its defaults
`timescale 1ns / 1ps
`default_nettype none
module center_out_pulse_trail_renderer_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    coptr_in_if.sink                              in_ch,
    coptr_out_if.source                           out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [coptr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [coptr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import coptr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    coptr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    coptr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (in_ch.command),
        .elapsed_ms    (in_ch.elapsed_ms),
        .pixel_index   (in_ch.pixel_index),
        .cmd           (cmd),
        .sts           (sts),
        .out_red       (out_ch.out_red),
        .out_green     (out_ch.out_green),
        .out_blue      (out_ch.out_blue),
        .live_pulses   (out_ch.live_pulses),
        .spawn_dropped (out_ch.spawn_dropped)
    );

    a_live_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.live_pulses <= LIVE_W'(MAX_PULSES))
        else $error("live pulse count above store size");

    a_drop_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.spawn_dropped |->
        out_ch.out_red == '0 && out_ch.out_green == '0 && out_ch.out_blue == '0)
        else $error("dropped spawn reported with a color");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !sts.div_busy)
        else $error("divider busy while taking a new word");

endmodule
`default_nettype wire

// ----- hdl/coptr_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module coptr_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [coptr_pkg::DEN_W-1:0]  rem_init,
    input  wire logic [coptr_pkg::PROD_W-1:0] low,
    input  wire logic [coptr_pkg::ITER_W-1:0] iters,
    input  wire logic [coptr_pkg::DEN_W-1:0]  den,
    output logic      [coptr_pkg::PROD_W-1:0] quo,
    output logic                              busy
);
    import coptr_pkg::*;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] low_reg, quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, low_reg[PROD_W-1]};
        fits  = trial >= {1'b0, den_reg};
        if (fits)
        begin
            rem_next = DEN_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            low_reg <= low;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[PROD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign busy = busy_reg;

endmodule
`default_nettype wire

// ----- hdl/coptr_dp.sv -----
// datapath: configuration, pulse store, walk logic and color math
`timescale 1ns / 1ps
`default_nettype none
module coptr_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [coptr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [coptr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             command,
    input  wire logic [coptr_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input  wire logic [coptr_pkg::PIX_W-1:0]      pixel_index,
    input  wire coptr_pkg::cmd_t                  cmd,
    output coptr_pkg::sts_t                       sts,
    output logic      [coptr_pkg::COL_W-1:0]      out_red,
    output logic      [coptr_pkg::COL_W-1:0]      out_green,
    output logic      [coptr_pkg::COL_W-1:0]      out_blue,
    output logic      [coptr_pkg::LIVE_W-1:0]     live_pulses,
    output logic                                  spawn_dropped
);
    import coptr_pkg::*;

    // configuration
    logic              en_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [INTV_W-1:0] intv_reg;
    logic [COL_W-1:0]  hred_reg, hgrn_reg, hblu_reg;

    // pulse store
    logic [OFF_W-1:0] loff_reg [MAX_PULSES];
    logic [OFF_W-1:0] roff_reg [MAX_PULSES];
    logic [MAX_PULSES-1:0] llive_reg, rlive_reg;
    logic [CNT_W-1:0] count_reg;
    logic [OFF_W-1:0] timer_reg;

    // per item
    logic                 cmdq_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [PK_W-1:0]      pk_reg;
    logic [LEN_W-1:0]     n_reg;
    logic [CTR_W-1:0]     c_reg;
    logic [LIM_W-1:0]     lim_reg;
    logic [CNT_W-1:0]     k_reg, w_reg;
    paint_t               kind_reg, kind_next;
    logic [SPAN_W-1:0]    d_reg, d_next;
    logic [BRI_W-1:0]     b_reg;
    logic [1:0]           ch_reg;
    logic [COL_W-1:0]     colr_reg, colg_reg, colb_reg;
    logic                 drop_reg;
    logic [COL_W-1:0]     ored_reg, ogrn_reg, oblu_reg;
    logic [LIVE_W-1:0]    olive_reg;
    logic                 odrop_reg;

    // step: speed split into whole LEDs and thousandths
    logic [SPQ_W-1:0]     spq_reg;
    logic [SPR_W-1:0]     spr;
    logic [STEP_W-1:0]    qe_reg, step_reg;
    logic [RCP_IN_W-1:0]  re_reg;
    logic [CX_W-1:0]      cx_reg;

    logic [LEN_W-1:0]  n_clamp;
    logic [CTR_W-1:0]  c_calc;
    logic [PIDX_W-1:0] idx;
    logic [OFF_W-1:0]  lo, ro;
    logic              ll, rl;
    logic [STEP_W-1:0] step;
    logic [OFF_W:0]    lsum, rsum, tsum;
    logic [OFF_W-1:0]  lnew, rnew, tnew;
    logic              lkeep, rkeep;
    logic [LEN_W-1:0]  half;

    logic signed [HEAD_W-1:0] cs, pks, lo_bnd, hi_bnd, head_l, head_r, dl, dr;
    logic hit_l, hit_r, trl, trr;

    logic                 div_start;
    logic [DEN_W-1:0]     div_rem, div_den;
    logic [PROD_W-1:0]    div_low, div_quo;
    logic [ITER_W-1:0]    div_iters;
    logic                 div_busy;
    logic [BX_W-1:0]      bx;
    logic [CX_W-1:0]      cx;
    logic [COL_W-1:0]     chan;

    // floor(x / 1000) by reciprocal multiply
    function automatic logic [RCP_Q_W-1:0] div_by_fix(input logic [RCP_IN_W-1:0] x);
        logic [RCP_P_W-1:0] p;
        p = RCP_P_W'(x) * RCP_P_W'(RCP_M);
        return p[RCP_P_W-1:RCP_SH];
    endfunction

    always_comb
    begin
        if (len_reg == '0)
        begin
            n_clamp = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_LEDS))
        begin
            n_clamp = LEN_W'(MAX_LEDS);
        end
        else
        begin
            n_clamp = len_reg;
        end
        c_calc = CTR_W'((n_clamp - LEN_W'(1)) * HALF_FIX);
    end

    assign idx  = k_reg[PIDX_W-1:0];
    assign lo   = loff_reg[idx];
    assign ro   = roff_reg[idx];
    assign ll   = llive_reg[idx];
    assign rl   = rlive_reg[idx];
    assign step = step_reg;
    assign half = n_reg >> 1;
    assign spr  = SPR_W'(speed_reg - SPEED_W'(spq_reg * FIX_ONE));

    // tick walk: advance both sides, saturate, retire
    always_comb
    begin
        lsum  = {1'b0, lo} + (OFF_W+1)'(step);
        rsum  = {1'b0, ro} + (OFF_W+1)'(step);
        lnew  = lsum[OFF_W] ? '1 : lsum[OFF_W-1:0];
        rnew  = rsum[OFF_W] ? '1 : rsum[OFF_W-1:0];
        lkeep = ll && !(lnew > OFF_W'(lim_reg));
        rkeep = rl && !(rnew > OFF_W'(lim_reg));
        tsum  = {1'b0, timer_reg} + (OFF_W+1)'(elapsed_reg);
        tnew  = tsum[OFF_W] ? '1 : tsum[OFF_W-1:0];
    end

    // query walk: later sides overwrite earlier ones
    always_comb
    begin
        cs     = HEAD_W'(c_reg);
        pks    = HEAD_W'(pk_reg);
        lo_bnd = (pix_reg == '0) ? pks - HEAD_W'(FIX_ONE - 1) : pks;
        hi_bnd = pks + HEAD_W'(FIX_ONE - 1);
        head_l = cs - HEAD_W'(lo);
        head_r = cs + HEAD_W'(ro);
        hit_l  = (head_l >= lo_bnd) && (head_l <= hi_bnd);
        hit_r  = (head_r >= lo_bnd) && (head_r <= hi_bnd);
        dl     = pks - head_l;
        dr     = head_r - pks;
        trl    = (LEN_W'(pix_reg) < half) && !dl[HEAD_W-1] && (dl != '0)
                 && (dl <= HEAD_W'(span_reg));
        trr    = (LEN_W'(pix_reg) >= half) && !dr[HEAD_W-1] && (dr != '0)
                 && (dr <= HEAD_W'(span_reg));
        kind_next = kind_reg;
        d_next    = d_reg;
        if (ll)
        begin
            if (hit_l)
            begin
                kind_next = PAINT_HEAD;
            end
            else if (trl)
            begin
                kind_next = PAINT_TRAIL;
                d_next    = dl[SPAN_W-1:0];
            end
        end
        if (rl)
        begin
            if (hit_r)
            begin
                kind_next = PAINT_HEAD;
            end
            else if (trr)
            begin
                kind_next = PAINT_TRAIL;
                d_next    = dr[SPAN_W-1:0];
            end
        end
    end

    // divider operands for the trail brightness, and the channel scale product
    always_comb
    begin
        bx = BX_W'(d_reg * FIX_ONE);
        case (ch_reg)
            2'd0:    chan = hred_reg;
            2'd1:    chan = hgrn_reg;
            default: chan = hblu_reg;
        endcase
        cx        = CX_W'(chan * b_reg);
        div_start = cmd.bright_start;
        div_rem   = bx[BX_W-1:BRI_W];
        div_low   = {bx[BRI_W-1:0], {(PROD_W-BRI_W){1'b0}}};
        div_iters = ITER_W'(BRI_W);
        div_den   = span_reg;
    end

    coptr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .low      (div_low),
        .iters    (div_iters),
        .den      (div_den),
        .quo      (div_quo),
        .busy     (div_busy)
    );

    // control state of the store and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            len_reg   <= LEN_W'(60);
            speed_reg <= SPEED_W'(20000);
            span_reg  <= SPAN_W'(15000);
            intv_reg  <= INTV_W'(1200);
            hred_reg  <= '0;
            hgrn_reg  <= '0;
            hblu_reg  <= COL_W'(255);
            llive_reg <= '0;
            rlive_reg <= '0;
            count_reg <= '0;
            timer_reg <= '0;
            k_reg     <= '0;
            w_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ENABLED:
                    begin
                        if (cfg_data[0] && !en_reg)
                        begin
                            llive_reg <= '0;
                            rlive_reg <= '0;
                            count_reg <= '0;
                            timer_reg <= '0;
                        end
                        en_reg <= cfg_data[0];
                    end
                    CFG_STRIP_LEN:  len_reg   <= cfg_data[LEN_W-1:0];
                    CFG_SPEED:      speed_reg <= cfg_data[SPEED_W-1:0];
                    CFG_TRAIL_SPAN: span_reg  <= cfg_data[SPAN_W-1:0];
                    CFG_INTERVAL:   intv_reg  <= cfg_data[INTV_W-1:0];
                    CFG_HEAD_RED:   hred_reg  <= cfg_data[COL_W-1:0];
                    CFG_HEAD_GREEN: hgrn_reg  <= cfg_data[COL_W-1:0];
                    CFG_HEAD_BLUE:  hblu_reg  <= cfg_data[COL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept || cmd.spawn)
            begin
                k_reg <= '0;
                w_reg <= '0;
            end
            if (cmd.spawn)
            begin
                if (tnew >= OFF_W'(intv_reg))
                begin
                    timer_reg <= '0;
                    if (count_reg < CNT_W'(MAX_PULSES))
                    begin
                        llive_reg[count_reg[PIDX_W-1:0]] <= 1'b1;
                        rlive_reg[count_reg[PIDX_W-1:0]] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else
                begin
                    timer_reg <= tnew;
                end
            end
            if (cmd.walk_tick)
            begin
                k_reg <= k_reg + 1'b1;
                if (lkeep || rkeep)
                begin
                    llive_reg[w_reg[PIDX_W-1:0]] <= lkeep;
                    rlive_reg[w_reg[PIDX_W-1:0]] <= rkeep;
                    w_reg <= w_reg + 1'b1;
                end
            end
            if (cmd.walk_end)
            begin
                count_reg <= w_reg;
            end
            if (cmd.walk_query)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // offsets, per-item payload, color math and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmdq_reg    <= command;
            elapsed_reg <= elapsed_ms;
            pix_reg     <= pixel_index;
            pk_reg      <= PK_W'(pixel_index * FIX_ONE);
            n_reg       <= n_clamp;
            c_reg       <= c_calc;
            lim_reg     <= LIM_W'(c_calc) + LIM_W'(span_reg);
            kind_reg    <= PAINT_NONE;
            d_reg       <= '0;
            drop_reg    <= 1'b0;
            spq_reg     <= SPQ_W'(div_by_fix(RCP_IN_W'(speed_reg)));
        end
        if (cmd.step_start)
        begin
            qe_reg <= STEP_W'(spq_reg) * STEP_W'(elapsed_reg);
            re_reg <= RCP_IN_W'(spr) * RCP_IN_W'(elapsed_reg);
        end
        step_reg <= qe_reg + STEP_W'(div_by_fix(re_reg));
        if (cmd.spawn && (tnew >= OFF_W'(intv_reg)))
        begin
            if (count_reg < CNT_W'(MAX_PULSES))
            begin
                loff_reg[count_reg[PIDX_W-1:0]] <= '0;
                roff_reg[count_reg[PIDX_W-1:0]] <= '0;
            end
            else
            begin
                drop_reg <= 1'b1;
            end
        end
        if (cmd.walk_tick && (lkeep || rkeep))
        begin
            loff_reg[w_reg[PIDX_W-1:0]] <= ll ? lnew : lo;
            roff_reg[w_reg[PIDX_W-1:0]] <= rl ? rnew : ro;
        end
        if (cmd.walk_query)
        begin
            kind_reg <= kind_next;
            d_reg    <= d_next;
        end
        if (cmd.bright_store)
        begin
            b_reg  <= BRI_W'(FIX_ONE) - div_quo[BRI_W-1:0];
            ch_reg <= 2'd0;
        end
        if (cmd.chan_start)
        begin
            cx_reg <= cx;
        end
        if (cmd.chan_store)
        begin
            case (ch_reg)
                2'd0:    colr_reg <= COL_W'(div_by_fix(RCP_IN_W'(cx_reg)));
                2'd1:    colg_reg <= COL_W'(div_by_fix(RCP_IN_W'(cx_reg)));
                default: colb_reg <= COL_W'(div_by_fix(RCP_IN_W'(cx_reg)));
            endcase
            ch_reg <= ch_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            unique case (kind_reg)
                PAINT_HEAD:
                begin
                    ored_reg <= hred_reg;
                    ogrn_reg <= hgrn_reg;
                    oblu_reg <= hblu_reg;
                end
                PAINT_TRAIL:
                begin
                    ored_reg <= colr_reg;
                    ogrn_reg <= colg_reg;
                    oblu_reg <= colb_reg;
                end
                default:
                begin
                    ored_reg <= '0;
                    ogrn_reg <= '0;
                    oblu_reg <= '0;
                end
            endcase
            olive_reg <= LIVE_W'(count_reg);
            odrop_reg <= drop_reg;
        end
    end

    always_comb
    begin
        sts.is_query  = cmdq_reg;
        sts.enabled   = en_reg;
        sts.in_range  = LEN_W'(pix_reg) < n_reg;
        sts.walk_done = k_reg >= count_reg;
        sts.is_trail  = kind_reg == PAINT_TRAIL;
        sts.div_busy  = div_busy;
        sts.ch_last   = ch_reg == 2'd2;
    end

    assign out_red       = ored_reg;
    assign out_green     = ogrn_reg;
    assign out_blue      = oblu_reg;
    assign live_pulses   = olive_reg;
    assign spawn_dropped = odrop_reg;

endmodule
`default_nettype wire

// ----- hdl/coptr_ctrl.sv -----
// controller state machine sequencing ticks and pixel queries
`timescale 1ns / 1ps
`default_nettype none
module coptr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire coptr_pkg::sts_t sts,
    output coptr_pkg::cmd_t      cmd
);
    import coptr_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECIDE = 12'b0000_0000_0010,
        S_T_DIV  = 12'b0000_0000_0100,
        S_T_WAIT = 12'b0000_0000_1000,
        S_SPAWN  = 12'b0000_0001_0000,
        S_T_WALK = 12'b0000_0010_0000,
        S_Q_WALK = 12'b0000_0100_0000,
        S_B_DIV  = 12'b0000_1000_0000,
        S_B_WAIT = 12'b0001_0000_0000,
        S_C_DIV  = 12'b0010_0000_0000,
        S_C_WAIT = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!sts.enabled)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.is_query)
                begin
                    state_next = S_T_DIV;
                end
                else if (sts.in_range)
                begin
                    state_next = S_Q_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_T_DIV:
            begin
                cmd.step_start = 1'b1;
                state_next     = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_SPAWN;
                end
            end
            S_SPAWN:
            begin
                cmd.spawn  = 1'b1;
                state_next = S_T_WALK;
            end
            S_T_WALK:
            begin
                if (sts.walk_done)
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.walk_tick = 1'b1;
                end
            end
            S_Q_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = sts.is_trail ? S_B_DIV : S_DONE;
                end
                else
                begin
                    cmd.walk_query = 1'b1;
                end
            end
            S_B_DIV:
            begin
                cmd.bright_start = 1'b1;
                state_next       = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.bright_store = 1'b1;
                    state_next       = S_C_DIV;
                end
            end
            S_C_DIV:
            begin
                cmd.chan_start = 1'b1;
                state_next     = S_C_WAIT;
            end
            S_C_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.chan_store = 1'b1;
                    state_next     = sts.ch_last ? S_DONE : S_C_DIV;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.finish)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ovalid_reg;

endmodule
`default_nettype wire

// ----- verif/center_out_pulse_trail_renderer_core_test.sv -----
// self-checking testbench for the center-out pulse trail renderer core
`timescale 1ns / 1ps
module center_out_pulse_trail_renderer_core_test;
    import coptr_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   LIMIT_CYCLES = 4000000;
    localparam int   DRAIN_CYCLES = 800;

    typedef struct {
        logic                 command;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic [PIX_W-1:0]     pixel_index;
    } item_t;

    typedef struct {
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
        logic [LIVE_W-1:0] live;
        logic              dropped;
    } pixel_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    coptr_in_if  in_ch ();
    coptr_out_if out_ch ();

    center_out_pulse_trail_renderer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    item_t       pending_items[$];
    pixel_word_t expected_words[$];
    int          errors;
    int          cycles;
    bit          calm;
    bit          in_taken;
    int          in_gap;
    int          out_gap;

    // predictor state
    bit            en;
    logic [10:0]   strip_len;
    logic [19:0]   speed;
    logic [19:0]   span;
    logic [15:0]   interval;
    logic [7:0]    head_r, head_g, head_b;
    logic [31:0]   left_off[MAX_PULSES];
    logic [31:0]   right_off[MAX_PULSES];
    bit            left_on[MAX_PULSES];
    bit            right_on[MAX_PULSES];
    int            pulses;
    logic [31:0]   timer_ms;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] sat_add(logic [31:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic longint strip_leds();
        longint n;
        n = strip_len;
        if (n < 1) n = 1;
        if (n > MAX_LEDS) n = MAX_LEDS;
        return n;
    endfunction

    task automatic clear_trail_state();
        for (int k = 0; k < MAX_PULSES; k++)
        begin
            left_off[k] = '0;
            right_off[k] = '0;
            left_on[k] = 0;
            right_on[k] = 0;
        end
        pulses = 0;
        timer_ms = '0;
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (cfg_idx_t'(idx))
            CFG_ENABLED:
            begin
                if (v[0] && !en) clear_trail_state();
                en = v[0];
            end
            CFG_STRIP_LEN:  strip_len = v[10:0];
            CFG_SPEED:      speed = v[19:0];
            CFG_TRAIL_SPAN: span = v[19:0];
            CFG_INTERVAL:   interval = v[15:0];
            CFG_HEAD_RED:   head_r = v[7:0];
            CFG_HEAD_GREEN: head_g = v[7:0];
            CFG_HEAD_BLUE:  head_b = v[7:0];
            default: ;
        endcase
    endtask

    function automatic void advance_pulses(logic [15:0] ms, output bit dropped);
        longint          n;
        longint unsigned lim;
        longint unsigned stp;
        int              w;
        n = strip_leds();
        lim = ((n - 1) * 1000) / 2 + span;
        stp = (longint'(speed) * ms) / 1000;
        dropped = 0;
        timer_ms = sat_add(timer_ms, ms);
        if (timer_ms >= interval)
        begin
            if (pulses < MAX_PULSES)
            begin
                left_off[pulses] = '0;
                right_off[pulses] = '0;
                left_on[pulses] = 1;
                right_on[pulses] = 1;
                pulses++;
            end
            else
                dropped = 1;
            timer_ms = '0;
        end
        for (int k = 0; k < pulses; k++)
        begin
            if (left_on[k])
            begin
                left_off[k] = sat_add(left_off[k], stp);
                if (longint'(left_off[k]) > lim) left_on[k] = 0;
            end
            if (right_on[k])
            begin
                right_off[k] = sat_add(right_off[k], stp);
                if (longint'(right_off[k]) > lim) right_on[k] = 0;
            end
        end
        w = 0;
        for (int k = 0; k < pulses; k++)
        begin
            if (left_on[k] || right_on[k])
            begin
                left_off[w] = left_off[k];
                right_off[w] = right_off[k];
                left_on[w] = left_on[k];
                right_on[w] = right_on[k];
                w++;
            end
        end
        for (int k = w; k < MAX_PULSES; k++)
        begin
            left_off[k] = '0;
            right_off[k] = '0;
            left_on[k] = 0;
            right_on[k] = 0;
        end
        pulses = w;
    endfunction

    function automatic void paint_half(longint head, longint p, longint n, bit is_left,
                                       ref pixel_word_t px);
        longint hi;
        longint d;
        longint b;
        hi = head / 1000;
        if (hi == p)
        begin
            if (p >= 0 && p < n)
            begin
                px.red = head_r;
                px.green = head_g;
                px.blue = head_b;
            end
            return;
        end
        if (is_left ? (p >= n / 2) : (p < n / 2 || p >= n)) return;
        if (span == 0) return;
        d = is_left ? (p * 1000 - head) : (head - p * 1000);
        if (d <= 0 || d > longint'(span)) return;
        b = 1000 - (d * 1000) / span;
        px.red = (head_r * b) / 1000;
        px.green = (head_g * b) / 1000;
        px.blue = (head_b * b) / 1000;
    endfunction

    function automatic pixel_word_t predict_word(item_t it);
        pixel_word_t px;
        longint      n;
        longint      c;
        bit          dr;
        px = '{default: '0};
        if (it.command == CMD_TICK)
        begin
            if (en)
            begin
                advance_pulses(it.elapsed_ms, dr);
                px.dropped = dr;
            end
        end
        else
        begin
            n = strip_leds();
            c = ((n - 1) * 1000) / 2;
            if (en && it.pixel_index < n)
                for (int k = 0; k < pulses; k++)
                begin
                    if (left_on[k])
                        paint_half(c - longint'(left_off[k]), it.pixel_index, n, 1, px);
                    if (right_on[k])
                        paint_half(c + longint'(right_off[k]), it.pixel_index, n, 0, px);
                end
        end
        px.live = LIVE_W'(pulses);
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // config writes and accepted words, in clock order
    always @(posedge clk)
    begin
        pixel_word_t guess;
        if (rst_n)
        begin
            if (cfg_we) apply_register(cfg_index, cfg_data);
            if (in_ch.valid && in_ch.ready)
            begin
                guess = predict_word('{in_ch.command, in_ch.elapsed_ms, in_ch.pixel_index});
                expected_words = {expected_words, guess};
            end
        end
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge clk)
    begin
        item_t it;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_taken)
            ;
        else if (in_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            in_gap--;
        end
        else if (pending_items.size() == 0)
            in_ch.valid <= 1'b0;
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            in_gap = $urandom_range(1, 12) - 1;
        end
        else
        begin
            it = pending_items.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.command <= it.command;
            in_ch.elapsed_ms <= it.elapsed_ms;
            in_ch.pixel_index <= it.pixel_index;
        end
    end

    // result side stalls
    always @(negedge clk)
    begin
        if (!rst_n || calm)
            out_ch.ready <= 1'b1;
        else if (out_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            out_gap--;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_ch.ready <= 1'b0;
            out_gap = $urandom_range(1, 12) - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_words.pop_front();
                if (out_ch.out_red !== want.red)
                    report_mismatch("out_red", out_ch.out_red, want.red);
                if (out_ch.out_green !== want.green)
                    report_mismatch("out_green", out_ch.out_green, want.green);
                if (out_ch.out_blue !== want.blue)
                    report_mismatch("out_blue", out_ch.out_blue, want.blue);
                if (out_ch.live_pulses !== want.live)
                    report_mismatch("live_pulses", out_ch.live_pulses, want.live);
                if (out_ch.spawn_dropped !== want.dropped)
                    report_mismatch("spawn_dropped", out_ch.spawn_dropped, want.dropped);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_register(cfg_idx_t idx, int unsigned v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_tick(int unsigned ms);
        item_t it;
        it = '{CMD_TICK, ms[15:0], 10'($urandom)};
        pending_items = {pending_items, it};
    endtask

    task automatic queue_query(int unsigned pix);
        item_t it;
        it = '{CMD_QUERY, 16'($urandom), pix[9:0]};
        pending_items = {pending_items, it};
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_settings();
        int unsigned v;
        case ($urandom_range(0, 9))
            0: v = 1;
            1: v = 2;
            2: v = 1024;
            3: v = 2047;
            4: v = 0;
            5: v = $urandom_range(3, 1023);
            default: v = $urandom_range(3, 120);
        endcase
        write_register(CFG_STRIP_LEN, v);
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 20'hFFFFF;
            2: v = 1000000;
            default: v = $urandom_range(500, 60000);
        endcase
        write_register(CFG_SPEED, v);
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 1;
            2: v = 20'hFFFFF;
            default: v = $urandom_range(1000, 30000);
        endcase
        write_register(CFG_TRAIL_SPAN, v);
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 65535;
            default: v = $urandom_range(1, 400);
        endcase
        write_register(CFG_INTERVAL, v);
        write_register(CFG_HEAD_RED, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
        write_register(CFG_HEAD_GREEN, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
        write_register(CFG_HEAD_BLUE, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: write_register(CFG_ENABLED, 0);
            1: write_register(CFG_ENABLED, 1);
            default:
            begin
                write_register(CFG_ENABLED, 0);
                write_register(CFG_ENABLED, 1);
            end
        endcase
    endtask

    initial begin
        int total;
        int n;
        errors = 0;
        cycles = 0;
        calm = 0;
        in_gap = 0;
        out_gap = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_TICK;
        in_ch.elapsed_ms = '0;
        in_ch.pixel_index = '0;
        out_ch.ready = 1'b0;
        en = 0;
        strip_len = 60;
        speed = 20000;
        span = 15000;
        interval = 1200;
        head_r = 0;
        head_g = 0;
        head_b = 255;
        clear_trail_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled block stays black and still
        queue_tick(65535);
        queue_query(30);
        wait_drained();

        write_register(CFG_STRIP_LEN, 9);
        write_register(CFG_SPEED, 1000);
        write_register(CFG_TRAIL_SPAN, 3000);
        write_register(CFG_INTERVAL, 0);
        write_register(CFG_HEAD_RED, 255);
        write_register(CFG_HEAD_GREEN, 128);
        write_register(CFG_HEAD_BLUE, 1);
        write_register(CFG_ENABLED, 1);
        for (int k = 0; k < 9; k++) queue_tick(k == 0 ? 0 : 300);
        for (int p = 0; p < 10; p++) queue_query(p);
        queue_query(1023);
        queue_tick(65535);
        queue_tick(0);
        wait_drained();

        total = 0;
        while (total < 1600)
        begin
            random_settings();
            n = $urandom_range(60, 140);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 19))
                        0: queue_tick(65535);
                        1: queue_tick($urandom_range(0, 65535));
                        2: queue_tick(0);
                        default: queue_tick($urandom_range(1, 150));
                    endcase
                end
                else if ($urandom_range(0, 7) == 0)
                    queue_query($urandom_range(0, 1023));
                else
                    queue_query($urandom_range(0, strip_len > 1024 ? 1023 :
                                                  (strip_len == 0 ? 2 : strip_len)));
            end
            total += n;
            if (total >= 1350) calm = 1;
            wait_drained();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/coptr_pkg.sv
hdl/coptr_if.sv
hdl/coptr_div.sv
hdl/coptr_dp.sv
hdl/coptr_ctrl.sv
hdl/center_out_pulse_trail_renderer_core.sv
verif/center_out_pulse_trail_renderer_core_test.sv
